@@ rtl/polygon_containment_clearance_assert.svh @@
// assertion helpers used by the checker file
`ifndef POLYGON_CONTAINMENT_CLEARANCE_ASSERT_SVH
`define POLYGON_CONTAINMENT_CLEARANCE_ASSERT_SVH

// checked only while out of reset
`define PCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define PCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/pcc_pkg.sv @@
`default_nettype none
package pcc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int COORD_BITS   = 24;
    localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = ADDR_BITS + 1;
    localparam int VCOUNT_BITS  = 9;
    localparam int IDX_BITS     = 8;
    localparam int DIST_BITS    = 50;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int MUL_BITS     = COORD_BITS + 3;
    localparam int PROD_BITS    = 2 * MUL_BITS;
    localparam int T_FRAC       = 16;
    localparam int T_BITS       = T_FRAC + 1;
    localparam int SQ_LIM       = 1 << (COORD_BITS + 1);

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_CLEARANCE_SQ = 1'b1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic [IDX_BITS-1:0]          vertex_index;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
    } t_in_item;

    typedef struct packed {
        logic                 inside_res;
        logic                 near_edge;
        logic                 blocked;
        logic [DIST_BITS-1:0] min_dist_sq;
    } t_out_item;

    typedef struct packed {
        logic                         start;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } t_edge_req;

    typedef struct packed {
        logic                 done;
        logic                 crossing;
        logic [DIST_BITS-1:0] dist_sq;
    } t_edge_res;

endpackage
`default_nettype wire

@@ rtl/polygon_containment_clearance.sv @@
// each edge is worked in the edge unit on one multiplier; the divide steps are skipped when the projection clamps
// a vertex write item leaves the block idle; a new item is taken once the previous query has ended
// the result register frees the input side while a result waits to be taken
// synchronous active-low reset clears control, vertex_count and clearance_sq
// vertex memory is not cleared; the user must write each vertex a query reads, the block does not check it
`default_nettype none
module polygon_containment_clearance (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire pcc_pkg::t_in_item              i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output pcc_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [pcc_pkg::DIST_BITS-1:0]  i_cfg_data
);

    localparam int AB = pcc_pkg::ADDR_BITS;
    localparam int CB = pcc_pkg::CNT_BITS;
    localparam int CW = pcc_pkg::COORD_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDPREV = 3'd1;
    localparam logic [2:0] S_RDCUR  = 3'd2;
    localparam logic [2:0] S_EDGE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                         r_state, n_state;
    logic [pcc_pkg::VCOUNT_BITS-1:0]    r_vcount;
    logic [pcc_pkg::DIST_BITS-1:0]      r_clear;
    logic [CB-1:0]                      r_n;
    logic [AB-1:0]                      r_idx;
    logic                               r_inside;
    logic [pcc_pkg::DIST_BITS-1:0]      r_best;
    logic signed [CW-1:0]               r_px, r_py, r_prevx, r_prevy;
    logic                               r_out_valid;
    pcc_pkg::t_out_item                 r_out;

    logic                               w_acc;
    logic                               w_query;
    logic                               w_wr;
    logic [CB-1:0]                      w_n;
    logic [AB-1:0]                      w_raddr;
    logic signed [CW-1:0]               w_rx, w_ry;
    logic                               w_last;
    logic                               w_load;
    logic                               w_near;
    pcc_pkg::t_edge_req                 w_req;
    pcc_pkg::t_edge_res                 w_res;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_query    = w_acc && (i_in_data.kind == pcc_pkg::KIND_QUERY);
    assign w_wr       = w_acc && (i_in_data.kind == pcc_pkg::KIND_WRITE) &&
                        (32'(i_in_data.vertex_index) < pcc_pkg::MAX_VERTICES);

    // counts above the memory depth use the whole memory
    assign w_n = (32'(r_vcount) > pcc_pkg::MAX_VERTICES) ?
                 CB'(pcc_pkg::MAX_VERTICES) : CB'(r_vcount);
    assign w_last = (CB'(r_idx) == r_n - CB'(1));
    assign w_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_near = (r_clear != '0) && (r_best < r_clear);

    always_comb begin
        case (r_state)
            S_IDLE:   w_raddr = AB'(w_n - CB'(1));
            S_RDPREV: w_raddr = '0;
            S_EDGE:   w_raddr = r_idx + AB'(1);
            default:  w_raddr = r_idx;
        endcase
    end

    pcc_vram u_vram (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (AB'(i_in_data.vertex_index)),
        .i_wx    (i_in_data.coord_x),
        .i_wy    (i_in_data.coord_y),
        .i_raddr (w_raddr),
        .o_rx    (w_rx),
        .o_ry    (w_ry)
    );

    // edge from the previous vertex to the one just read
    assign w_req.start = (r_state == S_RDCUR);
    assign w_req.ax    = r_prevx;
    assign w_req.ay    = r_prevy;
    assign w_req.bx    = w_rx;
    assign w_req.by    = w_ry;
    assign w_req.px    = r_px;
    assign w_req.py    = r_py;

    pcc_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_query) n_state = (w_n == '0) ? S_DONE : S_RDPREV;
            end
            S_RDPREV: n_state = S_RDCUR;
            S_RDCUR:  n_state = S_EDGE;
            S_EDGE: begin
                if (w_res.done) n_state = w_last ? S_DONE : S_RDCUR;
            end
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= '0;
            r_clear     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcc_pkg::CFG_VERTEX_COUNT:
                        r_vcount <= i_cfg_data[pcc_pkg::VCOUNT_BITS-1:0];
                    default: r_clear <= i_cfg_data;
                endcase
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_px     <= i_in_data.coord_x;
                r_py     <= i_in_data.coord_y;
                r_n      <= w_n;
                r_idx    <= '0;
                r_inside <= 1'b0;
                r_best   <= pcc_pkg::DIST_MAX;
            end
            S_RDPREV: begin
                r_prevx <= w_rx;
                r_prevy <= w_ry;
            end
            S_RDCUR: begin
                r_prevx <= w_rx;
                r_prevy <= w_ry;
            end
            S_EDGE: begin
                if (w_res.done) begin
                    r_inside <= r_inside ^ w_res.crossing;
                    if (w_res.dist_sq < r_best) r_best <= w_res.dist_sq;
                    r_idx <= r_idx + AB'(1);
                end
            end
            default: ;
        endcase
        if (w_load) begin
            r_out.inside_res  <= r_inside;
            r_out.near_edge   <= w_near;
            r_out.blocked     <= r_inside || w_near;
            r_out.min_dist_sq <= r_best;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ rtl/pcc_vram.sv @@
`default_nettype none
module pcc_vram (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [pcc_pkg::ADDR_BITS-1:0]          i_waddr,
    input  wire logic signed [pcc_pkg::COORD_BITS-1:0]  i_wx,
    input  wire logic signed [pcc_pkg::COORD_BITS-1:0]  i_wy,
    input  wire logic [pcc_pkg::ADDR_BITS-1:0]          i_raddr,
    output logic signed [pcc_pkg::COORD_BITS-1:0]       o_rx,
    output logic signed [pcc_pkg::COORD_BITS-1:0]       o_ry
);

    logic signed [pcc_pkg::COORD_BITS-1:0] r_mem_x [pcc_pkg::MAX_VERTICES];
    logic signed [pcc_pkg::COORD_BITS-1:0] r_mem_y [pcc_pkg::MAX_VERTICES];
    logic signed [pcc_pkg::COORD_BITS-1:0] r_rx;
    logic signed [pcc_pkg::COORD_BITS-1:0] r_ry;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_x[i_waddr] <= i_wx;
            r_mem_y[i_waddr] <= i_wy;
        end
        r_rx <= r_mem_x[i_raddr];
        r_ry <= r_mem_y[i_raddr];
    end

    assign o_rx = r_rx;
    assign o_ry = r_ry;

endmodule
`default_nettype wire

@@ rtl/pcc_edge.sv @@
`default_nettype none
module pcc_edge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pcc_pkg::t_edge_req i_req,
    output pcc_pkg::t_edge_res     o_res
);

    localparam int DB = pcc_pkg::DIST_BITS;
    localparam int MB = pcc_pkg::MUL_BITS;
    localparam int PB = pcc_pkg::PROD_BITS;
    localparam int FB = pcc_pkg::DIFF_BITS;
    localparam int TB = pcc_pkg::T_BITS;

    localparam logic [3:0] E_IDLE = 4'd0;
    localparam logic [3:0] E_L2A  = 4'd1;
    localparam logic [3:0] E_L2B  = 4'd2;
    localparam logic [3:0] E_DOTA = 4'd3;
    localparam logic [3:0] E_DOTB = 4'd4;
    localparam logic [3:0] E_CRA  = 4'd5;
    localparam logic [3:0] E_CRB  = 4'd6;
    localparam logic [3:0] E_CRC  = 4'd7;
    localparam logic [3:0] E_DIV  = 4'd8;
    localparam logic [3:0] E_OFA  = 4'd9;
    localparam logic [3:0] E_OFB  = 4'd10;
    localparam logic [3:0] E_OFC  = 4'd11;
    localparam logic [3:0] E_SQA  = 4'd12;
    localparam logic [3:0] E_SQB  = 4'd13;
    localparam logic [3:0] E_SUM  = 4'd14;

    logic [3:0]           r_state, n_state;
    logic [3:0]           r_cnt;
    logic                 r_done;
    logic signed [FB-1:0] r_abx, r_aby, r_apx, r_apy, r_bpx, r_bpy, r_dxv, r_dyv;
    logic                 r_span;
    logic [DB-1:0]        r_l2;
    logic signed [DB:0]   r_dot;
    logic signed [PB-1:0] r_lhs;
    logic signed [PB-1:0] r_prod;
    logic [DB-1:0]        r_rem;
    logic [TB-1:0]        r_t;
    logic signed [MB-1:0] r_dx, r_dy;
    logic [DB:0]          r_sqx;
    logic                 r_crossing;
    logic [DB-1:0]        r_dist;

    logic signed [MB-1:0] m_a, m_b;
    logic signed [PB-1:0] w_mul;
    logic signed [MB-1:0] w_tval;
    logic [DB:0]          w_rs;
    logic                 w_ge;
    logic [DB+1:0]        w_sum;
    logic                 w_big;
    logic signed [MB-1:0] w_lim;

    assign w_tval = $signed({{(MB-TB){1'b0}}, r_t});
    assign w_lim  = MB'(pcc_pkg::SQ_LIM);

    // one shared multiplier, operands picked by step
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            E_L2A:  begin m_a = MB'(r_abx); m_b = MB'(r_abx); end
            E_L2B:  begin m_a = MB'(r_aby); m_b = MB'(r_aby); end
            E_DOTA: begin m_a = MB'(r_apx); m_b = MB'(r_abx); end
            E_DOTB: begin m_a = MB'(r_apy); m_b = MB'(r_aby); end
            E_CRA:  begin m_a = MB'(r_bpx); m_b = MB'(r_dyv); end
            E_CRB:  begin m_a = MB'(r_dxv); m_b = MB'(r_bpy); end
            E_OFA:  begin m_a = MB'(r_abx); m_b = w_tval; end
            E_OFB:  begin m_a = MB'(r_aby); m_b = w_tval; end
            E_SQA:  begin m_a = r_dx; m_b = r_dx; end
            E_SQB:  begin m_a = r_dy; m_b = r_dy; end
            default: begin m_a = '0; m_b = '0; end
        endcase
    end

    assign w_mul = m_a * m_b;
    assign w_rs  = {r_rem, 1'b0};
    assign w_ge  = w_rs >= {1'b0, r_l2};
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_prod[DB:0]};
    assign w_big = (r_dx > w_lim) || (r_dx < -w_lim) || (r_dy > w_lim) || (r_dy < -w_lim);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            E_IDLE: if (i_req.start) n_state = E_L2A;
            E_L2A:  n_state = E_L2B;
            E_L2B:  n_state = E_DOTA;
            E_DOTA: n_state = E_DOTB;
            E_DOTB: n_state = E_CRA;
            E_CRA:  n_state = E_CRB;
            E_CRB:  n_state = E_CRC;
            E_CRC: begin
                if (r_l2 == '0 || r_dot <= 0 || r_dot >= $signed({1'b0, r_l2})) begin
                    n_state = E_OFA;
                end else begin
                    n_state = E_DIV;
                end
            end
            E_DIV:  if (r_cnt == 4'(pcc_pkg::T_FRAC - 1)) n_state = E_OFA;
            E_OFA:  n_state = E_OFB;
            E_OFB:  n_state = E_OFC;
            E_OFC:  n_state = E_SQA;
            E_SQA:  n_state = E_SQB;
            E_SQB:  n_state = E_SUM;
            E_SUM:  n_state = E_IDLE;
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == E_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul;
        case (r_state)
            E_IDLE: begin
                r_abx  <= FB'(i_req.bx) - FB'(i_req.ax);
                r_aby  <= FB'(i_req.by) - FB'(i_req.ay);
                r_apx  <= FB'(i_req.px) - FB'(i_req.ax);
                r_apy  <= FB'(i_req.py) - FB'(i_req.ay);
                r_bpx  <= FB'(i_req.px) - FB'(i_req.bx);
                r_bpy  <= FB'(i_req.py) - FB'(i_req.by);
                r_dxv  <= FB'(i_req.ax) - FB'(i_req.bx);
                r_dyv  <= FB'(i_req.ay) - FB'(i_req.by);
                r_span <= (i_req.by > i_req.py) != (i_req.ay > i_req.py);
            end
            E_L2B:  r_l2  <= r_prod[DB-1:0];
            E_DOTA: r_l2  <= r_l2 + r_prod[DB-1:0];
            E_DOTB: r_dot <= (DB+1)'(r_prod);
            E_CRA:  r_dot <= r_dot + (DB+1)'(r_prod);
            E_CRB:  r_lhs <= r_prod;
            E_CRC: begin
                // sign of the edge's y step picks the side of the comparison
                r_crossing <= r_span && ((r_dyv > 0) ? (r_lhs < r_prod) : (r_prod < r_lhs));
                r_cnt   <= '0;
                r_rem   <= DB'(r_dot);
                if (r_l2 == '0 || r_dot <= 0) begin
                    r_t <= '0;
                end else if (r_dot >= $signed({1'b0, r_l2})) begin
                    r_t <= TB'(1) << pcc_pkg::T_FRAC;
                end else begin
                    r_t <= '0;
                end
            end
            E_DIV: begin
                r_rem <= w_ge ? DB'(w_rs - {1'b0, r_l2}) : DB'(w_rs);
                r_t   <= {r_t[TB-2:0], w_ge};
                r_cnt <= r_cnt + 4'd1;
            end
            // arithmetic shift gives the floored offset
            E_OFB: r_dx <= MB'(r_apx) - MB'(r_prod >>> pcc_pkg::T_FRAC);
            E_OFC: r_dy <= MB'(r_apy) - MB'(r_prod >>> pcc_pkg::T_FRAC);
            E_SQB: r_sqx <= r_prod[DB:0];
            E_SUM: r_dist <= (w_big || w_sum > (DB+2)'(pcc_pkg::DIST_MAX)) ?
                             pcc_pkg::DIST_MAX : w_sum[DB-1:0];
            default: ;
        endcase
    end

    assign o_res.done     = r_done;
    assign o_res.crossing = r_crossing;
    assign o_res.dist_sq  = r_dist;

endmodule
`default_nettype wire

@@ rtl/pcc_checker.sv @@
`default_nettype none
`include "polygon_containment_clearance_assert.svh"
module pcc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire pcc_pkg::t_in_item              i_in_data,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire pcc_pkg::t_out_item             o_out_data
);

    `PCC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")
    `PCC_ASSERT(a_blocked, o_out_valid |-> o_out_data.blocked == (o_out_data.inside_res || o_out_data.near_edge), "blocked disagrees with inside and near")
    `PCC_ASSERT(a_near_dist, o_out_valid && o_out_data.near_edge |-> o_out_data.min_dist_sq != pcc_pkg::DIST_MAX, "near flagged at saturated distance")
    `PCC_ASSERT(a_write_silent, i_in_valid && o_in_ready && i_in_data.kind == pcc_pkg::KIND_WRITE && !o_out_valid |=> !o_out_valid, "vertex write produced a result")
    `PCC_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind polygon_containment_clearance pcc_checker u_pcc_checker (.*);
`default_nettype wire
